// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/tgpg_pkg.sv
package tgpg_pkg;

  // Default block parameters
  localparam int unsigned FirstCodeDef   = 32;
  localparam int unsigned LastCodeDef    = 126;
  localparam int unsigned TextColumnsDef = 40;
  localparam int unsigned TextRowsDef    = 15;
  localparam int unsigned GlyphHeightDef = 16;

  // Field widths
  localparam int unsigned RowW   = 4;
  localparam int unsigned ColW   = 6;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned AttrW  = 8;
  localparam int unsigned LineW  = 4;
  localparam int unsigned GlyphW = 8;
  localparam int unsigned XW     = 9;
  localparam int unsigned YW     = 8;
  localparam int unsigned ColorW = 16;
  localparam int unsigned PixelsPerLine = 8;

  // Font store: code offset (7 bits) by glyph line (4 bits)
  localparam int unsigned OffW      = 7;
  localparam int unsigned FontAddrW = OffW + LineW;
  localparam int unsigned SpaceCode = 32;

  // Configuration registers
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned NumRegs = 8;
  localparam logic [CfgIdxW-1:0] RegNormalBg = 4'd0;
  localparam logic [CfgIdxW-1:0] RegNormalFg = 4'd1;
  localparam logic [CfgIdxW-1:0] RegSelectBg = 4'd2;
  localparam logic [CfgIdxW-1:0] RegSelectFg = 4'd3;
  localparam logic [CfgIdxW-1:0] RegAlertBg  = 4'd4;
  localparam logic [CfgIdxW-1:0] RegAlertFg  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegEditBg   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegEditFg   = 4'd7;

  localparam logic [ColorW-1:0] RstNormalBg = 16'h0000;
  localparam logic [ColorW-1:0] RstNormalFg = 16'hFFFF;
  localparam logic [ColorW-1:0] RstSelectBg = 16'h18C6;
  localparam logic [ColorW-1:0] RstSelectFg = 16'h0000;
  localparam logic [ColorW-1:0] RstAlertBg  = 16'h00F8;
  localparam logic [ColorW-1:0] RstAlertFg  = 16'hFFFF;
  localparam logic [ColorW-1:0] RstEditBg   = 16'hE0FF;
  localparam logic [ColorW-1:0] RstEditFg   = 16'h0000;

  // Attribute palette pairs
  localparam logic [1:0] PairNormal = 2'd0;
  localparam logic [1:0] PairSelect = 2'd1;
  localparam logic [1:0] PairAlert  = 2'd2;
  localparam logic [1:0] PairEdit   = 2'd3;

  // Request opcodes
  localparam logic OpFontWrite = 1'b0;
  localparam logic OpDraw      = 1'b1;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  // Font store write request
  typedef struct packed {
    logic                 en;
    logic [FontAddrW-1:0] addr;
    logic [GlyphW-1:0]    data;
  } font_wr_t;

  // Font store read request
  typedef struct packed {
    logic                 en;
    logic [FontAddrW-1:0] addr;
  } font_rd_t;

endpackage

// File: rtl/core/tgpg_font_mem.sv
module tgpg_font_mem (
  input  logic                                clk_i,
  input  tgpg_pkg::font_wr_t                  wr_i,
  input  tgpg_pkg::font_rd_t                  rd_i,
  output logic [tgpg_pkg::GlyphW-1:0]         rdata_o
);
  import tgpg_pkg::*;

  localparam int unsigned Depth = 1 << FontAddrW;

  logic [GlyphW-1:0] mem_q [Depth];
  logic [GlyphW-1:0] rdata_q;

  // Write one glyph line
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read; hold data while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/text_glyph_pixel_generator.sv
// Draw request: each line passes the font read register and the output register,
// one line per cycle while the output is not stalled; 16 lines (GLYPH_HEIGHT) per
// character, one font read each. Font write request: no result. A new request is
// taken once the last font read of the previous character is issued.
// Reset clears control state and the palette registers to their defaults;
// font store content is undefined until written.
`include "assert_macros.svh"

module text_glyph_pixel_generator #(
  parameter int unsigned FIRST_CODE   = tgpg_pkg::FirstCodeDef,
  parameter int unsigned LAST_CODE    = tgpg_pkg::LastCodeDef,
  parameter int unsigned TEXT_COLUMNS = tgpg_pkg::TextColumnsDef,
  parameter int unsigned TEXT_ROWS    = tgpg_pkg::TextRowsDef,
  parameter int unsigned GLYPH_HEIGHT = tgpg_pkg::GlyphHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [tgpg_pkg::RowW-1:0]     text_row_i,
  input  logic [tgpg_pkg::ColW-1:0]     text_col_i,
  input  logic [tgpg_pkg::CodeW-1:0]    char_code_i,
  input  logic [tgpg_pkg::AttrW-1:0]    attribute_i,
  input  logic [tgpg_pkg::LineW-1:0]    glyph_line_i,
  input  logic [tgpg_pkg::GlyphW-1:0]   font_bits_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tgpg_pkg::XW-1:0]       pixel_x_o,
  output logic [tgpg_pkg::YW-1:0]       pixel_y_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_0_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_1_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_2_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_3_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_4_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_5_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_6_o,
  output logic [tgpg_pkg::ColorW-1:0]   pixel_7_o,
  output logic                          last_line_o,
  // Configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tgpg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgpg_pkg::ColorW-1:0]   cfg_data_i
);
  import tgpg_pkg::*;

  localparam bit SpaceInFont = (SpaceCode >= FIRST_CODE) && (SpaceCode <= LAST_CODE);
  localparam logic [OffW-1:0] FirstOff = OffW'(FIRST_CODE);
  localparam logic [OffW-1:0] SpaceOff = OffW'(SpaceCode - FIRST_CODE);
  localparam logic [LineW-1:0] LastLine = LineW'(GLYPH_HEIGHT - 1);

  // Control state
  state_e state_q, state_d;
  logic [LineW-1:0] line_q, line_d;

  // Per-character context
  logic [OffW-1:0] off_q;
  logic [XW-1:0]   x_q;
  logic [YW-1:0]   ybase_q;
  logic [1:0]      pair_q;
  logic            blank_q;

  // Read data stage
  logic            rdv_q;
  logic [XW-1:0]   s1_x_q;
  logic [YW-1:0]   s1_y_q;
  logic [1:0]      s1_pair_q;
  logic            s1_blank_q;
  logic            s1_last_q;

  // Output register
  logic                out_valid_q;
  logic [XW-1:0]       out_x_q;
  logic [YW-1:0]       out_y_q;
  logic [ColorW-1:0]   out_pix_q [PixelsPerLine];
  logic                out_last_q;

  logic [ColorW-1:0] palette_q [NumRegs];

  font_wr_t          font_wr;
  font_rd_t          font_rd;
  logic [GlyphW-1:0] font_rdata;
  logic [GlyphW-1:0] glyph;
  logic [ColorW-1:0] bg, fg;

  logic in_fire, draw_ok, code_ok, out_load, rd_en;

  // Decode request
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign code_ok    = (32'(char_code_i) >= FIRST_CODE) && (32'(char_code_i) <= LAST_CODE) &&
                      !char_code_i[CodeW-1];
  assign draw_ok    = (32'(text_row_i) < TEXT_ROWS) && (32'(text_col_i) < TEXT_COLUMNS);

  // Font write port
  always_comb begin
    font_wr.en   = in_fire && (op_i == OpFontWrite) && code_ok &&
                   (32'(glyph_line_i) < GLYPH_HEIGHT);
    font_wr.addr = {char_code_i[OffW-1:0] - FirstOff, glyph_line_i};
    font_wr.data = font_bits_i;
  end

  // Advance pipeline
  assign out_load     = rdv_q && (!out_valid_q || out_ready_i);
  assign rd_en        = (state_q == StRun) && (!rdv_q || out_load);
  assign font_rd.en   = rd_en;
  assign font_rd.addr = {off_q, line_q};

  tgpg_font_mem u_font_mem (
    .clk_i   (clk_i),
    .wr_i    (font_wr),
    .rd_i    (font_rd),
    .rdata_o (font_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (op_i == OpDraw) && draw_ok) begin
          state_d = StRun;
          line_d  = '0;
        end
      end
      StRun: begin
        if (rd_en) begin
          line_d = line_q + 1'b1;
          if (line_q == LastLine) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      line_q  <= '0;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
    end
  end

  // Latch character context on draw
  always_ff @(posedge clk_i) begin
    if (in_fire && (op_i == OpDraw)) begin
      off_q   <= code_ok ? (char_code_i[OffW-1:0] - FirstOff) : SpaceOff;
      blank_q <= !code_ok && !SpaceInFont;
      x_q     <= {text_col_i, 3'b000};
      ybase_q <= YW'(32'(text_row_i) * GLYPH_HEIGHT);
      pair_q  <= attribute_i[1:0];
    end
  end

  // Track read data stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv_q <= 1'b0;
    end else if (rd_en) begin
      rdv_q <= 1'b1;
    end else if (out_load) begin
      rdv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_x_q     <= x_q;
      s1_y_q     <= ybase_q + YW'(line_q);
      s1_pair_q  <= pair_q;
      s1_blank_q <= blank_q;
      s1_last_q  <= (line_q == LastLine);
    end
  end

  // Pick palette pair
  always_comb begin
    unique case (s1_pair_q)
      PairNormal: begin bg = palette_q[RegNormalBg[2:0]]; fg = palette_q[RegNormalFg[2:0]]; end
      PairSelect: begin bg = palette_q[RegSelectBg[2:0]]; fg = palette_q[RegSelectFg[2:0]]; end
      PairAlert:  begin bg = palette_q[RegAlertBg[2:0]];  fg = palette_q[RegAlertFg[2:0]];  end
      PairEdit:   begin bg = palette_q[RegEditBg[2:0]];   fg = palette_q[RegEditFg[2:0]];   end
      default:    begin bg = palette_q[RegNormalBg[2:0]]; fg = palette_q[RegNormalFg[2:0]]; end
    endcase
  end

  assign glyph = s1_blank_q ? '0 : font_rdata;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= s1_x_q;
      out_y_q    <= s1_y_q;
      out_last_q <= s1_last_q;
      for (int k = 0; k < PixelsPerLine; k++) begin
        out_pix_q[k] <= glyph[PixelsPerLine-1-k] ? fg : bg;
      end
    end
  end

  // Palette registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q[0] <= RstNormalBg;
      palette_q[1] <= RstNormalFg;
      palette_q[2] <= RstSelectBg;
      palette_q[3] <= RstSelectFg;
      palette_q[4] <= RstAlertBg;
      palette_q[5] <= RstAlertFg;
      palette_q[6] <= RstEditBg;
      palette_q[7] <= RstEditFg;
    end else if (cfg_valid_i && (32'(cfg_index_i) < NumRegs)) begin
      palette_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = out_x_q;
  assign pixel_y_o   = out_y_q;
  assign pixel_0_o   = out_pix_q[0];
  assign pixel_1_o   = out_pix_q[1];
  assign pixel_2_o   = out_pix_q[2];
  assign pixel_3_o   = out_pix_q[3];
  assign pixel_4_o   = out_pix_q[4];
  assign pixel_5_o   = out_pix_q[5];
  assign pixel_6_o   = out_pix_q[6];
  assign pixel_7_o   = out_pix_q[7];
  assign last_line_o = out_last_q;

  // Checks
  `ASSERT_SAME(a_wr_no_rd, clk_i, rst_ni, font_wr.en, !rd_en)
  `ASSERT_NEXT(a_rd_lands, clk_i, rst_ni, rd_en, rdv_q)
  `ASSERT_NEXT(a_rd_hold, clk_i, rst_ni, rdv_q && !out_load, rdv_q && $stable(font_rdata))
  `ASSERT_NEXT(a_draw_runs, clk_i, rst_ni, in_fire && (op_i == OpDraw) && draw_ok,
               state_q == StRun)

endmodule

// File: test/tb_text_glyph_pixel_generator.sv
module tb_text_glyph_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import tgpg_pkg::*;

  localparam int FontDepth    = 2 ** FontAddrW;
  localparam int LineStride   = 2 ** LineW;
  localparam int ResetCycles  = 11;
  localparam int QuietCycles  = 8;
  localparam int DrainCycles  = 24;
  localparam int PhaseItems   = 40;
  localparam int MaxReports   = 10;

  // Palette registers in index order
  localparam logic [0:NumRegs-1][CfgIdxW-1:0] PaletteRegs = {
    RegNormalBg, RegNormalFg, RegSelectBg, RegSelectFg,
    RegAlertBg, RegAlertFg, RegEditBg, RegEditFg
  };

  // Space glyph, one line per entry, chosen to hit edge and alternating bits
  localparam logic [0:15][GlyphW-1:0] SpacePattern = {
    8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0,
    8'h18, 8'h24, 8'h42, 8'h81, 8'hC3, 8'h3C, 8'h7E, 8'hE7
  };

  typedef struct packed {
    logic              op;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [CodeW-1:0]  code;
    logic [AttrW-1:0]  attr;
    logic [LineW-1:0]  gline;
    logic [GlyphW-1:0] bits;
  } glyph_req_t;

  typedef struct packed {
    logic [XW-1:0]                        x;
    logic [YW-1:0]                        y;
    logic [PixelsPerLine-1:0][ColorW-1:0] px;
    logic                                 last;
  } glyph_line_t;

  // Raster model of the character generator: palette, font copy, lines due
  class char_cell_raster;
    logic [ColorW-1:0] colors [NumRegs];
    logic [GlyphW-1:0] font_mem [FontDepth];
    bit                font_set [FontDepth];
    glyph_line_t       lines_due [$];
    int unsigned       mismatches;

    function new();
      colors = '{RstNormalBg, RstNormalFg, RstSelectBg, RstSelectFg,
                 RstAlertBg, RstAlertFg, RstEditBg, RstEditFg};
      mismatches = 0;
    endfunction

    function bit in_font(int code);
      return code >= FirstCodeDef && code <= LastCodeDef && code < 128;
    endfunction

    function bit glyph_ready(int code);
      if (!in_font(code)) return 1'b0;
      for (int l = 0; l < GlyphHeightDef; l++)
        if (!font_set[(code - FirstCodeDef) * LineStride + l]) return 1'b0;
      return 1'b1;
    endfunction

    // Request that changes the store or produces lines
    function bit effective(glyph_req_t r);
      if (r.op == OpFontWrite) return in_font(r.code);
      return r.row < TextRowsDef && r.col < TextColumnsDef;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] val);
      if (idx < NumRegs) colors[idx[2:0]] = val;
    endfunction

    // Apply an accepted request: store a glyph line or queue sixteen lines
    function void take_request(glyph_req_t r);
      int                code;
      int                addr;
      logic [ColorW-1:0] bg;
      logic [ColorW-1:0] fg;
      logic [GlyphW-1:0] g;
      glyph_line_t       ln;
      code = r.code;
      if (r.op == OpFontWrite) begin
        if (in_font(code) && r.gline < GlyphHeightDef) begin
          addr = (code - FirstCodeDef) * LineStride + r.gline;
          font_mem[addr] = r.bits;
          font_set[addr] = 1'b1;
        end
        return;
      end
      if (r.row >= TextRowsDef || r.col >= TextColumnsDef) return;
      if (!in_font(code)) code = SpaceCode;
      bg = colors[{r.attr[1:0], 1'b0}];
      fg = colors[{r.attr[1:0], 1'b1}];
      for (int l = 0; l < GlyphHeightDef; l++) begin
        g = in_font(code) ? font_mem[(code - FirstCodeDef) * LineStride + l] : '0;
        ln.x = {r.col, 3'b000};
        ln.y = YW'(int'(r.row) * GlyphHeightDef + l);
        for (int k = 0; k < PixelsPerLine; k++)
          ln.px[k] = g[PixelsPerLine - 1 - k] ? fg : bg;
        ln.last = (l == GlyphHeightDef - 1);
        lines_due.push_back(ln);
      end
    endfunction

    // Compare one accepted line with the oldest line due
    function void match_line(glyph_line_t got);
      glyph_line_t want;
      bit          bad;
      if (lines_due.size() == 0) begin
        if (mismatches < MaxReports)
          $display("line with nothing pending: x=%0d y=%0d last=%0b px=%h",
                   got.x, got.y, got.last, got.px);
        mismatches++;
        return;
      end
      want = lines_due.pop_front();
      bad = (got.x !== want.x) || (got.y !== want.y) || (got.last !== want.last);
      for (int k = 0; k < PixelsPerLine; k++)
        bad = bad || (got.px[k] !== want.px[k]);
      if (bad) begin
        if (mismatches < MaxReports)
          $display("line mismatch: expected x=%0d y=%0d last=%0b px=%h, got x=%0d y=%0d last=%0b px=%h",
                   want.x, want.y, want.last, want.px, got.x, got.y, got.last, got.px);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                op_i = OpFontWrite;
  logic [RowW-1:0]     text_row_i = '0;
  logic [ColW-1:0]     text_col_i = '0;
  logic [CodeW-1:0]    char_code_i = '0;
  logic [AttrW-1:0]    attribute_i = '0;
  logic [LineW-1:0]    glyph_line_i = '0;
  logic [GlyphW-1:0]   font_bits_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [XW-1:0]       pixel_x_o;
  logic [YW-1:0]       pixel_y_o;
  logic [ColorW-1:0]   pixel_0_o, pixel_1_o, pixel_2_o, pixel_3_o;
  logic [ColorW-1:0]   pixel_4_o, pixel_5_o, pixel_6_o, pixel_7_o;
  logic                last_line_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ColorW-1:0]   cfg_data_i = '0;

  char_cell_raster board;
  bit              calm = 1'b0;
  int              stall_left = 0;

  text_glyph_pixel_generator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .text_row_i   (text_row_i),
    .text_col_i   (text_col_i),
    .char_code_i  (char_code_i),
    .attribute_i  (attribute_i),
    .glyph_line_i (glyph_line_i),
    .font_bits_i  (font_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_0_o    (pixel_0_o),
    .pixel_1_o    (pixel_1_o),
    .pixel_2_o    (pixel_2_o),
    .pixel_3_o    (pixel_3_o),
    .pixel_4_o    (pixel_4_o),
    .pixel_5_o    (pixel_5_o),
    .pixel_6_o    (pixel_6_o),
    .pixel_7_o    (pixel_7_o),
    .last_line_o  (last_line_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long; none in calm stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ColorW-1:0] pick_color();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ColorW'($urandom);
  endfunction

  function automatic glyph_req_t any_fields();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(glyph_req_t)-1:0];
  endfunction

  // Code for a draw: outside the font (drawn as space) or a fully written glyph
  function automatic logic [CodeW-1:0] pick_drawn_code();
    logic [CodeW-1:0] ready_codes [$];
    if ($urandom_range(0, 3) == 0)
      return $urandom_range(0, 1) ? CodeW'($urandom_range(0, FirstCodeDef - 1))
                                  : CodeW'($urandom_range(LastCodeDef + 1, 255));
    for (int c = FirstCodeDef; c <= LastCodeDef; c++)
      if (board.glyph_ready(c)) ready_codes.push_back(CodeW'(c));
    return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
  endfunction

  function automatic glyph_req_t make_draw();
    glyph_req_t r;
    int         roll;
    r = any_fields();
    roll = $urandom_range(0, 99);
    r.op = OpDraw;
    r.code = pick_drawn_code();
    r.row = RowW'($urandom_range(0, TextRowsDef - 1));
    r.col = ColW'($urandom_range(0, TextColumnsDef - 1));
    // Occasionally place the cell off screen
    if (roll < 6)
      r.row = RowW'($urandom_range(TextRowsDef, 2 ** RowW - 1));
    else if (roll < 14)
      r.col = ColW'($urandom_range(TextColumnsDef, 2 ** ColW - 1));
    return r;
  endfunction

  function automatic glyph_req_t make_font_write();
    glyph_req_t r;
    r = any_fields();
    r.op = OpFontWrite;
    if ($urandom_range(0, 3) == 0)
      r.code = $urandom_range(0, 1) ? CodeW'($urandom_range(0, FirstCodeDef - 1))
                                    : CodeW'($urandom_range(LastCodeDef + 1, 255));
    else
      r.code = CodeW'($urandom_range(FirstCodeDef, LastCodeDef));
    return r;
  endfunction

  // Offer one request, hold it until taken, then update the model
  task automatic send_request(glyph_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= r.op;
    text_row_i   <= r.row;
    text_col_i   <= r.col;
    char_code_i  <= r.code;
    attribute_i  <= r.attr;
    glyph_line_i <= r.gline;
    font_bits_i  <= r.bits;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_request(r);
  endtask

  task automatic close_requests();
    in_valid_i <= 1'b0;
  endtask

  // Write all sixteen lines of one glyph
  task automatic write_glyph(logic [CodeW-1:0] code, bit patterned);
    glyph_req_t r;
    for (int l = 0; l < LineStride; l++) begin
      r = any_fields();
      r.op = OpFontWrite;
      r.code = code;
      r.gline = LineW'(l);
      if (patterned) r.bits = SpacePattern[l];
      send_request(r);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic close_cfg();
    cfg_valid_i <= 1'b0;
  endtask

  // Drain every line due, then give font writes time to land
  task automatic settle(int pad);
    while (board.lines_due.size() != 0) @(posedge clk_i);
    repeat (pad) @(posedge clk_i);
  endtask

  // Mostly draws of loaded glyphs, with glyph loads and stray writes mixed in
  task automatic random_phase(int target);
    int         done;
    int         roll;
    glyph_req_t r;
    done = 0;
    while (done < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        write_glyph(CodeW'($urandom_range(FirstCodeDef, LastCodeDef)), 1'b0);
        done += LineStride;
      end else begin
        r = (roll < 25) ? make_font_write() : make_draw();
        if (board.effective(r)) done++;
        send_request(r);
      end
    end
    close_requests();
    settle(QuietCycles);
  endtask

  // Accept lines and check them; drop ready in random stretches
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.match_line(glyph_line_t'({pixel_x_o, pixel_y_o,
                                      pixel_7_o, pixel_6_o, pixel_5_o, pixel_4_o,
                                      pixel_3_o, pixel_2_o, pixel_1_o, pixel_0_o,
                                      last_line_o}));
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  initial begin
    board = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load the space glyph and the last glyph of the font
    calm = 1'b1;
    write_glyph(CodeW'(SpaceCode), 1'b1);
    write_glyph(CodeW'(LastCodeDef), 1'b0);
    calm = 1'b0;

    // Font range edges for draws and font writes, codes drawn as space, off-screen cells, every pair
    send_request('{OpDraw, 4'd0, 6'd0, CodeW'(FirstCodeDef), 8'h00, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd14, 6'd39, CodeW'(LastCodeDef), 8'h01, 4'hF, 8'hFF});
    send_request('{OpDraw, 4'd3, 6'd5, CodeW'(FirstCodeDef - 1), 8'h02, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd9, 6'd17, CodeW'(LastCodeDef + 1), 8'hFF, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd1, 6'd1, 8'h80, 8'hFC, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd2, 6'd38, 8'hFF, 8'h7E, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd8, 6'd32, 8'h00, 8'h81, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd15, 6'd0, CodeW'(SpaceCode), 8'h00, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd0, 6'd40, CodeW'(SpaceCode), 8'h01, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd15, 6'd63, CodeW'(LastCodeDef), 8'h03, 4'd0, 8'h00});
    send_request('{OpFontWrite, 4'd0, 6'd0, CodeW'(FirstCodeDef - 1), 8'h00, 4'd0, 8'hFF});
    send_request('{OpFontWrite, 4'd0, 6'd0, CodeW'(LastCodeDef + 1), 8'h00, 4'hF, 8'hFF});
    send_request('{OpFontWrite, 4'd0, 6'd0, 8'hFF, 8'h00, 4'd7, 8'hAA});
    send_request('{OpFontWrite, 4'd0, 6'd0, 8'h00, 8'h00, 4'd3, 8'h55});
    send_request('{OpFontWrite, 4'd5, 6'd9, CodeW'(LastCodeDef), 8'h00, 4'hF, 8'h00});
    send_request('{OpFontWrite, 4'd0, 6'd0, CodeW'(FirstCodeDef), 8'h00, 4'd0, 8'h81});
    send_request('{OpDraw, 4'd7, 6'd20, CodeW'(LastCodeDef), 8'h02, 4'd0, 8'h00});
    send_request('{OpDraw, 4'd4, 6'd0, 8'hC8, 8'h00, 4'd0, 8'h00});
    close_requests();
    settle(QuietCycles);

    // All palette bits set
    for (int i = 0; i < NumRegs; i++) write_reg(PaletteRegs[i], '1);
    close_cfg();
    random_phase(PhaseItems);

    // All palette bits clear, no idling
    calm = 1'b1;
    for (int i = 0; i < NumRegs; i++) write_reg(PaletteRegs[i], '0);
    close_cfg();
    random_phase(PhaseItems);
    calm = 1'b0;

    // Random palette, plus writes to indexes past the palette
    for (int i = 0; i < NumRegs; i++) write_reg(PaletteRegs[i], pick_color());
    for (int j = NumRegs; j < 2 ** CfgIdxW; j++)
      write_reg(CfgIdxW'(j), ColorW'($urandom));
    close_cfg();
    random_phase(PhaseItems);

    // Update part of the palette
    for (int i = 0; i < NumRegs; i++)
      if ($urandom_range(0, 1)) write_reg(PaletteRegs[i], pick_color());
    close_cfg();
    random_phase(PhaseItems);

    settle(DrainCycles);
    if (board.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Hard stop on a hang
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
